FILE: hw/rtl/sfvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfvs_pkg
// shared types and constants for the stereo fade / volume / saturate unit
// ----------------------------------------------------------------------------
package sfvs_pkg;

	localparam int SAMPLE_W = 32;     // input sample width
	localparam int GAIN_W   = 24;     // master volume and gain width (unsigned 8.16)
	localparam int POS_W    = 32;     // sample position counter width
	localparam int FRAC_W   = 16;     // fraction bits of the fade factor
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH   = 1'd1;

	localparam logic [GAIN_W-1:0] MASTER_VOLUME_RST = 24'd65536;
	localparam logic [GAIN_W-1:0] FADE_LENGTH_RST   = 24'd176400;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQUARE,
		ST_GAIN,
		ST_MUL,
		ST_SAT,
		ST_OUT
	} state_t;

	// lane stage enables
	typedef struct packed {
		logic mul_en;
		logic sat_en;
	} lane_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfvs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfvs_div
// restoring divider, one quotient bit a cycle: (num << 16) / den, num < den
// ----------------------------------------------------------------------------
module sfvs_div
	import sfvs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [GAIN_W-1:0] num,
	input  wire logic [GAIN_W-1:0] den,
	output logic                   done,
	output logic [FRAC_W-1:0]      quot
);

	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GAIN_W-1:0] rem_q;
	logic [GAIN_W-1:0] den_q;
	logic [FRAC_W-1:0] quot_q;

	logic [GAIN_W:0]   rem2;
	logic              take;

	assign rem2 = {rem_q, 1'b0};
	assign take = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits suffice
			rem_q  <= take ? GAIN_W'(rem2 - {1'b0, den_q}) : rem2[GAIN_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sfvs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfvs_lane
// one channel: sample times gain, arithmetic shift, saturate to OUT_BITS
// ----------------------------------------------------------------------------
module sfvs_lane
	import sfvs_pkg::*;
#(
	parameter int OUT_BITS = 16
) (
	input  wire logic                       clk,
	input  wire lane_ctl_t                  ctl,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [GAIN_W-1:0]          gain,
	output logic signed [OUT_BITS-1:0]      result
);

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int SHIFT  = FRAC_W + (GAIN_W - OUT_BITS);

	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [PROD_W-1:0]   shd;
	logic                       pos_ovf;
	logic                       neg_ovf;
	logic signed [OUT_BITS-1:0] sat;
	logic signed [OUT_BITS-1:0] result_s2;

	assign prod = sample * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= prod;
		end
	end

	// floor shift, then check that the upper bits are all sign
	assign shd     = prod_s1 >>> SHIFT;
	assign pos_ovf = !shd[PROD_W-1] && (|shd[PROD_W-1:OUT_BITS-1]);
	assign neg_ovf = shd[PROD_W-1] && !(&shd[PROD_W-1:OUT_BITS-1]);

	always_comb begin
		if (pos_ovf) begin
			sat = {1'b0, {(OUT_BITS-1){1'b1}}};
		end else if (neg_ovf) begin
			sat = {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			sat = shd[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sat_en) begin
			result_s2 <= sat;
		end
	end

	assign result = result_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/stereo_fade_volume_saturate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_fade_volume_saturate_unit
// stereo gain stage with quadratic fade-out and saturation to OUT_BITS
// ----------------------------------------------------------------------------
// sequence: while fading, an item passes the bit-serial divider, ST_SQUARE and
//   ST_GAIN (only the divider at fade factor one), then ST_MUL, ST_SAT, ST_OUT
// flow: one item at a time (input ready only in ST_IDLE), held by output stall;
//   an item that ends the fade gives no output and frees the input next cycle
// reset: position 0, no fade armed, done flag clear, unity volume,
//   fade length 176400 samples, output empty
// ----------------------------------------------------------------------------
module stereo_fade_volume_saturate_unit
	import sfvs_pkg::*;
#(
	parameter int OUT_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input stream
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [2*SAMPLE_W-1:0]     s_tdata,   // left_in, right_in
	input  wire logic                      s_tuser,   // start_fade
	// output stream
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [((2*OUT_BITS+7)/8)*8-1:0] m_tdata,  // left_out, right_out, zero pad
	output logic                           m_tuser,   // fade_done
	// register write channel
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [GAIN_W-1:0]         cfg_data
);

	localparam int TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;

	// registers
	logic [GAIN_W-1:0] master_q;
	logic [GAIN_W-1:0] fade_len_q;

	// fade state
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  start_q;
	logic              ended_q;

	// current item
	state_t                   state_q, state_d;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                     done_flag_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [FRAC_W-1:0]        f_q;
	logic [2*FRAC_W-1:0]      ff_q;

	// output register
	logic                       m_tvalid_q;
	logic signed [OUT_BITS-1:0] m_left_q;
	logic signed [OUT_BITS-1:0] m_right_q;
	logic                       m_done_q;

	// accept-time decode
	logic              in_xfer;
	logic [POS_W-1:0]  start_new;
	logic              fading;
	logic [POS_W-1:0]  elapsed;
	logic              past_end;
	logic              drop;

	logic              div_start;
	logic              div_done;
	logic [FRAC_W-1:0] div_quot;

	logic [2*FRAC_W+GAIN_W-1:0] gain_prod;
	lane_ctl_t                  lane_ctl;
	logic signed [OUT_BITS-1:0] left_res;
	logic signed [OUT_BITS-1:0] right_res;
	logic                       out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;

	// a start flag arms the fade at this very sample
	assign start_new = s_tuser ? pos_q : start_q;
	assign fading    = (pos_q >= start_new);
	assign elapsed   = pos_q - start_new;
	assign past_end  = (elapsed >= {{(POS_W-GAIN_W){1'b0}}, fade_len_q});
	// first sample past the fade end is swallowed
	assign drop      = fading && past_end && !ended_q;

	assign div_start = in_xfer && fading && !past_end;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q   <= MASTER_VOLUME_RST;
			fade_len_q <= FADE_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MASTER_VOLUME: master_q   <= cfg_data;
				CFG_FADE_LENGTH:   fade_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position, fade start and sticky done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '1;
			ended_q <= 1'b0;
		end else if (in_xfer) begin
			pos_q   <= pos_q + 1'b1;
			start_q <= start_new;
			if (drop) begin
				ended_q <= 1'b1;
			end
		end
	end

	// fade factor divider: elapsed * 2^16 / fade_length
	sfvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed[GAIN_W-1:0]),
		.den    (fade_len_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_load = !m_tvalid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		lane_ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && !drop) begin
					state_d = div_start ? ST_DIV : ST_MUL;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					// zero quotient means full gain, skip the squaring
					state_d = (div_quot == '0) ? ST_MUL : ST_SQUARE;
				end
			end
			ST_SQUARE: state_d = ST_GAIN;
			ST_GAIN:   state_d = ST_MUL;
			ST_MUL: begin
				lane_ctl.mul_en = 1'b1;
				state_d         = ST_SAT;
			end
			ST_SAT: begin
				lane_ctl.sat_en = 1'b1;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign gain_prod = ff_q * master_q;

	// item datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_q      <= s_tdata[SAMPLE_W-1:0];
			right_q     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			done_flag_q <= ended_q;
			// no fade yet: plain volume; fade over: silence
			gain_q      <= !fading ? master_q : (past_end ? '0 : master_q);
		end
		if (state_q == ST_DIV && div_done) begin
			f_q <= FRAC_W'(~div_quot + 1'b1);   // 1.0 - q, only used when q is nonzero
		end
		if (state_q == ST_SQUARE) begin
			ff_q <= f_q * f_q;
		end
		if (state_q == ST_GAIN) begin
			gain_q <= gain_prod[2*FRAC_W+GAIN_W-1:2*FRAC_W];
		end
	end

	// one lane per channel
	sfvs_lane #(
		.OUT_BITS (OUT_BITS)
	) u_lane_left (
		.clk    (clk),
		.ctl    (lane_ctl),
		.sample (left_q),
		.gain   (gain_q),
		.result (left_res)
	);

	sfvs_lane #(
		.OUT_BITS (OUT_BITS)
	) u_lane_right (
		.clk    (clk),
		.ctl    (lane_ctl),
		.sample (right_q),
		.gain   (gain_q),
		.result (right_res)
	);

	// merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_load) begin
			m_left_q  <= left_res;
			m_right_q <= right_res;
			m_done_q  <= done_flag_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'({m_right_q, m_left_q});
	assign m_tuser  = m_done_q;

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stereo fade / volume / saturate unit: a queue
// driven input stream, a randomly stalled output stream and a bit-true
// predictor of gain, quadratic fade-out, fade end and 16-bit saturation
// ----------------------------------------------------------------------------
module tb;
	import sfvs_pkg::*;

	localparam int     OUT_BITS    = 16;
	localparam int     SHIFT_TOTAL = 16 + (24 - OUT_BITS);
	localparam longint OUT_MAX     = (longint'(1) << (OUT_BITS - 1)) - 1;
	localparam longint OUT_MIN     = -(longint'(1) << (OUT_BITS - 1));
	localparam int     TDATA_OUT_W = ((2 * OUT_BITS + 7) / 8) * 8;
	// watchdog limit, well above the longest correct gap without any transfer
	localparam int     QUIET_LIMIT = 2000;
	// drain time, longer than a fading item takes; covers an item that ends the fade
	localparam int     DRAIN_CYCLES = 30;

	// one stereo input item
	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                start;
	} sample_pair_t;

	// one scaled output item
	typedef struct packed {
		logic signed [OUT_BITS-1:0] left;
		logic signed [OUT_BITS-1:0] right;
		logic                       done;
	} faded_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [2*SAMPLE_W-1:0]         s_tdata = '0;   // left_in, right_in
	logic                          s_tuser = 1'b0; // start_fade
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0]        m_tdata;        // left_out, right_out
	logic                          m_tuser;        // fade_done
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = CFG_MASTER_VOLUME;
	logic [GAIN_W-1:0]             cfg_data = '0;

	// predictor state, mirrors the unit after reset
	logic [GAIN_W-1:0] volume     = MASTER_VOLUME_RST;
	logic [GAIN_W-1:0] fade_len   = FADE_LENGTH_RST;
	logic [POS_W-1:0]  play_pos   = '0;
	logic [POS_W-1:0]  fade_from  = '1;
	logic              fade_over  = 1'b0;

	sample_pair_t pending_pairs[$];
	faded_pair_t  faded_pairs[$];
	sample_pair_t in_flight;

	int src_pct = 0;
	int sink_pct = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	stereo_fade_volume_saturate_unit #(
		.OUT_BITS(OUT_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// master volume times the squared remaining fade fraction
	function automatic logic [GAIN_W-1:0] fade_gain(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] elapsed;
		longint           remain;
		if (pos < fade_from)
			return volume;
		elapsed = pos - fade_from;
		if (elapsed >= fade_len)
			return '0;
		remain = 65536 - ((longint'(elapsed) << FRAC_W) / longint'(fade_len));
		remain = remain * remain;
		return GAIN_W'((remain * longint'(volume)) >> 32);
	endfunction

	// exact product, floor shift, saturate with no intermediate wrap
	function automatic logic signed [OUT_BITS-1:0] scale_sat(input logic [SAMPLE_W-1:0] smp,
			input logic [GAIN_W-1:0] gain);
		longint prod;
		prod = (longint'($signed(smp)) * longint'({8'd0, gain})) >>> SHIFT_TOTAL;
		if (prod > OUT_MAX)
			prod = OUT_MAX;
		else if (prod < OUT_MIN)
			prod = OUT_MIN;
		return prod[OUT_BITS-1:0];
	endfunction

	// advance the position, detect the fade end, queue the scaled pair
	function automatic void fade_and_scale(input sample_pair_t item);
		logic [POS_W-1:0]  pos;
		logic [GAIN_W-1:0] gain;
		faded_pair_t       res;
		pos = play_pos;
		if (item.start)
			fade_from = pos;
		play_pos = pos + 1'b1;
		// first sample past the fade end is swallowed and latches done
		if (pos >= fade_from && !fade_over && (pos - fade_from) >= fade_len) begin
			fade_over = 1'b1;
			return;
		end
		gain = fade_gain(pos);
		res.left = scale_sat(item.left, gain);
		res.right = scale_sat(item.right, gain);
		res.done = fade_over;
		faded_pairs.push_back(res);
	endfunction

	// ------------------------------------------------------------------
	// input driver: predicts every accepted transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				fade_and_scale(in_flight);
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					in_flight = pending_pairs.pop_front();
					s_tdata <= {in_flight.right, in_flight.left};
					s_tuser <= in_flight.start;
					s_tvalid <= 1'b1;
					// idle burst before the next item
					if ($urandom_range(0, 99) < src_pct)
						src_gap = $urandom_range(1, 17);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// output monitor: random stall bursts, in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		faded_pair_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (faded_pairs.size() == 0) begin
					$display("%0t unexpected output: expected none, actual %0d %0d %0b",
						$time, $signed(m_tdata[OUT_BITS-1:0]),
						$signed(m_tdata[2*OUT_BITS-1:OUT_BITS]), m_tuser);
					mismatches++;
				end else begin
					want = faded_pairs.pop_front();
					if (m_tdata[OUT_BITS-1:0] !== want.left) begin
						$display("%0t left_out mismatch: expected %0d, actual %0d", $time,
							want.left, $signed(m_tdata[OUT_BITS-1:0]));
						mismatches++;
					end
					if (m_tdata[2*OUT_BITS-1:OUT_BITS] !== want.right) begin
						$display("%0t right_out mismatch: expected %0d, actual %0d", $time,
							want.right, $signed(m_tdata[2*OUT_BITS-1:OUT_BITS]));
						mismatches++;
					end
					if (m_tuser !== want.done) begin
						$display("%0t fade_done mismatch: expected %0b, actual %0b", $time,
							want.done, m_tuser);
						mismatches++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < sink_pct)
					sink_gap = $urandom_range(1, 17);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	task automatic queue_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
			input logic st);
		pending_pairs.push_back('{l, r, st});
	endtask

	// wait until every expected pair is out and the unit has gone quiet
	task automatic settle();
		do
			@(negedge clk);
		while (pending_pairs.size() != 0 || s_tvalid || faded_pairs.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MASTER_VOLUME: volume = val;
			CFG_FADE_LENGTH:   fade_len = val;
			default: ;
		endcase
	endtask

	// mostly about 24 significant bits, some 10-bit, full range and rail values
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0: return r;
			1: begin
				case (r[1:0])
					2'd0: return 32'h7FFF_FFFF;
					2'd1: return 32'h8000_0000;
					2'd2: return 32'h007F_FFFF;
					default: return 32'hFF80_0000;
				endcase
			end
			2: return {{23{r[9]}}, r[8:0]};
			default: return {{8{r[23]}}, r[23:0]};
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_volume();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return MASTER_VOLUME_RST;
			3: return GAIN_W'($urandom_range(0, 24'h02_0000));
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_fade_len();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return 24'd1;
			2: return '1;
			3: return GAIN_W'($urandom_range(2, 64));
			4: return GAIN_W'($urandom_range(65, 4000));
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	// one block of random traffic; before the fade end only long fades are used
	task automatic random_phase(input bit after_end, input bit no_idle);
		int odds;
		settle();
		if (after_end) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_MASTER_VOLUME, pick_volume());
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_FADE_LENGTH, pick_fade_len());
			odds = 20;
		end else begin
			write_reg(CFG_MASTER_VOLUME, pick_volume());
			write_reg(CFG_FADE_LENGTH, GAIN_W'($urandom_range(3000, 24'hFF_FFFF)));
			odds = 50;
		end
		src_pct = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
		sink_pct = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
		repeat ($urandom_range(110, 140))
			queue_pair(pick_sample(), pick_sample(), $urandom_range(0, odds - 1) == 0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: unity gain, no fade; rails, saturation, floor rounding
		queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		queue_pair(32'h007F_FFFF, 32'hFF80_0000, 1'b0);
		queue_pair(32'h0080_0000, 32'hFF7F_FFFF, 1'b0);
		queue_pair(32'h0000_0100, 32'hFFFF_FF00, 1'b0);
		queue_pair(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		settle();

		// zero volume
		write_reg(CFG_MASTER_VOLUME, '0);
		queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		queue_pair(32'h0012_3456, 32'hFFED_CBA9, 1'b0);
		settle();

		// full volume, longest fade just started
		write_reg(CFG_MASTER_VOLUME, '1);
		write_reg(CFG_FADE_LENGTH, '1);
		queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		queue_pair(32'h007F_FFFF, 32'hFF80_0000, 1'b0);
		queue_pair(32'h0000_1234, 32'hFFFF_EDCC, 1'b0);

		// long fades with random content, done stays low
		repeat (5)
			random_phase(1'b0, 1'b0);
		settle();

		// short fade runs out: four faded pairs, a swallowed one, then silence
		write_reg(CFG_MASTER_VOLUME, MASTER_VOLUME_RST);
		write_reg(CFG_FADE_LENGTH, 24'd4);
		queue_pair(32'h0040_0000, 32'hFFC0_0000, 1'b1);
		repeat (5)
			queue_pair(32'h0040_0000, 32'hFFC0_0000, 1'b0);
		settle();

		// zero fade length silences at once
		write_reg(CFG_FADE_LENGTH, '0);
		queue_pair(32'h0040_0000, 32'hFFC0_0000, 1'b1);
		queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		settle();

		// restart after the end brings the gain back, done stays set
		write_reg(CFG_MASTER_VOLUME, '1);
		write_reg(CFG_FADE_LENGTH, 24'd3);
		queue_pair(32'h0040_0000, 32'hFFC0_0000, 1'b1);
		queue_pair(32'h007F_FFFF, 32'hFF80_0000, 1'b0);
		queue_pair(32'h0000_8000, 32'hFFFF_8000, 1'b0);

		repeat (8)
			random_phase(1'b1, 1'b0);
		// closing stretch without idling on either side
		random_phase(1'b1, 1'b1);
		settle();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
